// ===== hdl/tebs_pkg.sv =====
// ----------------------------------------------------------------------------
// tebs_pkg
// Shared constants and codes for the two-ended buffer sub-allocator.
// ----------------------------------------------------------------------------
package tebs_pkg;

    localparam int ENTRIES_DEF   = 32;
    localparam int SIZE_BITS_DEF = 27;
    localparam int TOTAL_RESET   = 4194304;

    localparam logic [1:0] CMD_ALLOC = 2'd0;
    localparam logic [1:0] CMD_FREE  = 2'd1;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NO_ROOM   = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_FULL      = 2'd3
    } t_status;

endpackage

// ===== hdl/tebs_ram.sv =====
// ----------------------------------------------------------------------------
// tebs_ram
// Table storage: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module tebs_ram #(
    parameter int DEPTH = tebs_pkg::ENTRIES_DEF,
    parameter int WIDTH = 3 * tebs_pkg::SIZE_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// ===== hdl/two_ended_buffer_suballocator.sv =====
// A query passes from S_IDLE to S_DONE, where its result is registered, and ready
// returns when the state is back in S_IDLE, so a new item is taken only after the last.
// Allocate and free read and evaluate each table entry scanned, read and write each
// entry shifted out, and pass decision states; each merge pass after a free rescans the
// spare list. A finished result waits for i_ready.
// Reset (synchronous, active low) clears fill counts and totals, markers to 0 and size.
// ----------------------------------------------------------------------------
// two_ended_buffer_suballocator
// Sub-allocates a region from both ends, with an exact-length spare list
// that is merged back into the gap after frees.
// ----------------------------------------------------------------------------
module two_ended_buffer_suballocator #(
    parameter int ENTRIES   = tebs_pkg::ENTRIES_DEF,
    parameter int SIZE_BITS = tebs_pkg::SIZE_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [1:0]           i_cmd,
    input  logic [15:0]          i_row_pitch,
    input  logic [15:0]          i_row_count,
    input  logic [SIZE_BITS-1:0] i_aligned_size,
    input  logic [SIZE_BITS-1:0] i_free_offset,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [1:0]           o_status,
    output logic [SIZE_BITS-1:0] o_buffer_offset,
    output logic                 o_is_primary,
    output logic                 o_recycled,
    output logic [SIZE_BITS-1:0] o_free_bytes,
    output logic [SIZE_BITS-1:0] o_used_bytes,
    output logic [SIZE_BITS-1:0] o_aligned_bytes,
    output logic [SIZE_BITS-1:0] o_fragmented_bytes,
    input  logic                 i_cfg_we,
    input  logic [SIZE_BITS-1:0] i_cfg_data
);

    localparam int SB    = SIZE_BITS;
    localparam int EW    = 3 * SB;
    localparam int IW    = $clog2(ENTRIES);
    localparam int CW    = $clog2(ENTRIES + 1);
    localparam int REQ_W = (SB > 32) ? SB : 32;

    typedef enum logic [15:0] {
        S_IDLE      = 16'h0001,
        S_SSCAN_RD  = 16'h0002,
        S_SSCAN_EV  = 16'h0004,
        S_ALLOC_DEC = 16'h0008,
        S_USCAN_RD  = 16'h0010,
        S_USCAN_EV  = 16'h0020,
        S_FREE_DEC  = 16'h0040,
        S_USH_RD    = 16'h0080,
        S_USH_WR    = 16'h0100,
        S_SSH_RD    = 16'h0200,
        S_SSH_WR    = 16'h0400,
        S_MERGE_CHK = 16'h0800,
        S_MSCAN_RD  = 16'h1000,
        S_MSCAN_EV  = 16'h2000,
        S_DONE      = 16'h4000,
        S_SPARE     = 16'h8000
    } t_state;

    t_state r_state, n_state;

    logic [SB-1:0]    r_low, r_high, r_ms, r_me;
    logic [SB-1:0]    r_used_tot, r_al_tot, r_sp_tot;
    logic [CW-1:0]    r_ucnt, r_scnt, r_idx;
    logic [SB-1:0]    r_asz, r_foff;
    logic [REQ_W-1:0] r_size;
    logic             r_found;
    logic [EW-1:0]    r_ent;
    tebs_pkg::t_status r_status;
    logic [SB-1:0]    r_off;
    logic             r_prim, r_rec;

    logic [31:0]      prod;
    logic [SB-1:0]    gap;
    logic [CW:0]      idx_nx;

    logic             u_we, s_we;
    logic [IW-1:0]    u_waddr, s_waddr, u_raddr, s_raddr;
    logic [EW-1:0]    u_wdata, s_wdata, u_q, s_q;

    logic [SB-1:0]    q_off, q_len, q_al, e_off, e_len, e_al;

    assign prod   = i_row_pitch * i_row_count;
    assign gap    = (r_high >= r_low) ? (r_high - r_low) : '0;
    assign idx_nx = {1'b0, r_idx} + 1'b1;
    assign o_ready = (r_state == S_IDLE);

    assign q_off = s_q[SB-1:0];
    assign q_len = s_q[2*SB-1:SB];
    assign q_al  = s_q[3*SB-1:2*SB];
    assign e_off = r_ent[SB-1:0];
    assign e_len = r_ent[2*SB-1:SB];
    assign e_al  = r_ent[3*SB-1:2*SB];

    // read addresses: shift states look one entry ahead
    assign u_raddr = (r_state == S_USH_RD) ? idx_nx[IW-1:0] : r_idx[IW-1:0];
    assign s_raddr = (r_state == S_SSH_RD) ? idx_nx[IW-1:0] : r_idx[IW-1:0];

    tebs_ram #(.DEPTH(ENTRIES), .WIDTH(EW)) u_used (
        .i_clk   (i_clk),
        .i_we    (u_we),
        .i_waddr (u_waddr),
        .i_wdata (u_wdata),
        .i_raddr (u_raddr),
        .o_rdata (u_q)
    );

    tebs_ram #(.DEPTH(ENTRIES), .WIDTH(EW)) u_spare (
        .i_clk   (i_clk),
        .i_we    (s_we),
        .i_waddr (s_waddr),
        .i_wdata (s_wdata),
        .i_raddr (s_raddr),
        .o_rdata (s_q)
    );

    always_comb begin
        u_we    = 1'b0;
        u_waddr = r_ucnt[IW-1:0];
        u_wdata = r_ent;
        s_we    = 1'b0;
        s_waddr = r_scnt[IW-1:0];
        s_wdata = r_ent;
        case (r_state)
            S_ALLOC_DEC: begin
                if (r_ucnt < CW'(ENTRIES)) begin
                    if (r_found) begin
                        u_we = 1'b1;
                    end else if (r_size <= REQ_W'(gap)) begin
                        u_we    = 1'b1;
                        u_wdata = {r_asz, r_size[SB-1:0],
                                   (r_asz != '0) ? (r_high - r_size[SB-1:0]) : r_low};
                    end
                end
            end
            S_USH_WR: begin
                u_we    = 1'b1;
                u_waddr = r_idx[IW-1:0];
                u_wdata = u_q;
            end
            S_SPARE: begin
                s_we = 1'b1;
            end
            S_SSH_WR: begin
                s_we    = 1'b1;
                s_waddr = r_idx[IW-1:0];
                s_wdata = s_q;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    if (i_cmd == tebs_pkg::CMD_ALLOC) begin
                        n_state = S_SSCAN_RD;
                    end else if (i_cmd == tebs_pkg::CMD_FREE) begin
                        n_state = S_USCAN_RD;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_SSCAN_RD:  n_state = (r_idx < r_scnt) ? S_SSCAN_EV : S_ALLOC_DEC;
            S_SSCAN_EV:  n_state = (REQ_W'(q_len) == r_size) ? S_ALLOC_DEC : S_SSCAN_RD;
            S_ALLOC_DEC: begin
                n_state = (r_found && r_ucnt < CW'(ENTRIES)) ? S_SSH_RD : S_DONE;
            end
            S_USCAN_RD:  n_state = (r_idx < r_ucnt) ? S_USCAN_EV : S_DONE;
            S_USCAN_EV:  n_state = (u_q[SB-1:0] == r_foff) ? S_FREE_DEC : S_USCAN_RD;
            S_FREE_DEC: begin
                if ((e_al != '0 && e_off == r_high) ||
                    (({1'b0, e_off} + {1'b0, e_len}) == {1'b0, r_low})) begin
                    n_state = S_USH_RD;
                end else if (r_scnt >= CW'(ENTRIES)) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_SPARE;
                end
            end
            S_SPARE:     n_state = S_USH_RD;
            S_USH_RD:    n_state = (idx_nx < {1'b0, r_ucnt}) ? S_USH_WR : S_MERGE_CHK;
            S_USH_WR:    n_state = S_USH_RD;
            S_SSH_RD:    n_state = (idx_nx < {1'b0, r_scnt}) ? S_SSH_WR : S_MERGE_CHK;
            S_SSH_WR:    n_state = S_SSH_RD;
            S_MERGE_CHK: begin
                n_state = (r_ms != r_low || r_me != r_high) ? S_MSCAN_RD : S_DONE;
            end
            S_MSCAN_RD:  n_state = (r_idx < r_scnt) ? S_MSCAN_EV : S_MERGE_CHK;
            S_MSCAN_EV: begin
                if ((q_al != '0 && q_off == r_high) ||
                    (q_al == '0 && ({1'b0, q_off} + {1'b0, q_len}) == {1'b0, r_low})) begin
                    n_state = S_SSH_RD;
                end else begin
                    n_state = S_MSCAN_RD;
                end
            end
            S_DONE:      n_state = (!o_valid || i_ready) ? S_IDLE : S_DONE;
            default:     n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_low      <= '0;
            r_high     <= SB'(tebs_pkg::TOTAL_RESET);
            r_ucnt     <= '0;
            r_scnt     <= '0;
            r_used_tot <= '0;
            r_al_tot   <= '0;
            r_sp_tot   <= '0;
            o_valid    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_valid && i_ready && r_state != S_DONE) begin
                o_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                r_low      <= '0;
                r_high     <= i_cfg_data;
                r_ucnt     <= '0;
                r_scnt     <= '0;
                r_used_tot <= '0;
                r_al_tot   <= '0;
                r_sp_tot   <= '0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_asz    <= i_aligned_size;
                        r_foff   <= i_free_offset;
                        r_size   <= (i_aligned_size != '0) ? REQ_W'(i_aligned_size)
                                                           : REQ_W'(prod);
                        r_idx    <= '0;
                        r_found  <= 1'b0;
                        r_ms     <= r_low;
                        r_me     <= r_high;
                        r_status <= tebs_pkg::ST_OK;
                        r_off    <= '0;
                        r_prim   <= 1'b0;
                        r_rec    <= 1'b0;
                    end
                end
                S_SSCAN_EV: begin
                    if (REQ_W'(q_len) == r_size) begin
                        r_found <= 1'b1;
                        r_ent   <= s_q;
                    end else begin
                        r_idx <= idx_nx[CW-1:0];
                    end
                end
                S_ALLOC_DEC: begin
                    if (r_found) begin
                        if (r_ucnt >= CW'(ENTRIES)) begin
                            r_status <= tebs_pkg::ST_FULL;
                        end else begin
                            r_off      <= e_off;
                            r_rec      <= 1'b1;
                            r_ucnt     <= r_ucnt + 1'b1;
                            r_used_tot <= r_used_tot + e_len;
                            r_al_tot   <= r_al_tot + e_al;
                            r_sp_tot   <= r_sp_tot - e_len;
                        end
                    end else if (r_size > REQ_W'(gap)) begin
                        r_status <= tebs_pkg::ST_NO_ROOM;
                    end else if (r_ucnt >= CW'(ENTRIES)) begin
                        r_status <= tebs_pkg::ST_FULL;
                    end else begin
                        if (r_asz != '0) begin
                            r_high <= r_high - r_size[SB-1:0];
                            r_off  <= r_high - r_size[SB-1:0];
                        end else begin
                            r_off  <= r_low;
                            r_prim <= (r_low == '0);
                            r_low  <= r_low + r_size[SB-1:0];
                        end
                        r_ucnt     <= r_ucnt + 1'b1;
                        r_used_tot <= r_used_tot + r_size[SB-1:0];
                        r_al_tot   <= r_al_tot + r_asz;
                    end
                end
                S_USCAN_RD: begin
                    if (r_idx >= r_ucnt) begin
                        r_status <= tebs_pkg::ST_NOT_FOUND;
                    end
                end
                S_USCAN_EV: begin
                    if (u_q[SB-1:0] == r_foff) begin
                        r_ent <= u_q;
                    end else begin
                        r_idx <= idx_nx[CW-1:0];
                    end
                end
                S_FREE_DEC: begin
                    if (e_al != '0 && e_off == r_high) begin
                        r_high <= r_high + e_len;
                    end else if (({1'b0, e_off} + {1'b0, e_len}) == {1'b0, r_low}) begin
                        r_low <= r_low - e_len;
                    end else if (r_scnt >= CW'(ENTRIES)) begin
                        r_status <= tebs_pkg::ST_FULL;
                    end
                    if (n_state != S_DONE) begin
                        r_used_tot <= r_used_tot - e_len;
                        r_al_tot   <= r_al_tot - e_al;
                    end
                end
                S_SPARE: begin
                    r_scnt   <= r_scnt + 1'b1;
                    r_sp_tot <= r_sp_tot + e_len;
                end
                S_USH_RD: begin
                    if (idx_nx >= {1'b0, r_ucnt}) begin
                        r_ucnt <= r_ucnt - 1'b1;
                    end
                end
                S_USH_WR: r_idx <= idx_nx[CW-1:0];
                S_SSH_RD: begin
                    if (idx_nx >= {1'b0, r_scnt}) begin
                        r_scnt <= r_scnt - 1'b1;
                    end
                end
                S_SSH_WR: r_idx <= idx_nx[CW-1:0];
                S_MERGE_CHK: begin
                    r_ms  <= r_low;
                    r_me  <= r_high;
                    r_idx <= '0;
                end
                S_MSCAN_EV: begin
                    if (q_al != '0 && q_off == r_high) begin
                        r_high   <= r_high + q_len;
                        r_sp_tot <= r_sp_tot - q_len;
                    end else if (q_al == '0 &&
                                 ({1'b0, q_off} + {1'b0, q_len}) == {1'b0, r_low}) begin
                        r_low    <= r_low - q_len;
                        r_sp_tot <= r_sp_tot - q_len;
                    end else begin
                        r_idx <= idx_nx[CW-1:0];
                    end
                end
                S_DONE: begin
                    if (!o_valid || i_ready) begin
                        o_valid            <= 1'b1;
                        o_status           <= r_status;
                        o_buffer_offset    <= r_off;
                        o_is_primary       <= r_prim;
                        o_recycled         <= r_rec;
                        o_free_bytes       <= gap;
                        o_used_bytes       <= r_used_tot;
                        o_aligned_bytes    <= r_al_tot;
                        o_fragmented_bytes <= r_sp_tot;
                    end
                end
                default: begin
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ucnt <= CW'(ENTRIES) && r_scnt <= CW'(ENTRIES))
        else $error("table fill count beyond depth");
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("ready while an item is in work");
    a_recycle_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_recycled) |-> (o_status == tebs_pkg::ST_OK && !o_is_primary))
        else $error("recycled result with bad status or primary flag");
    a_fail_zero_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != tebs_pkg::ST_OK) |-> (o_buffer_offset == '0))
        else $error("failed item reports an offset");
`endif

endmodule

// ===== bench/tb.sv =====
// ----------------------------------------------------------------------------
// tb - two-ended buffer sub-allocator testbench
// Feeds allocate, free and query items through the valid/ready ports and
// checks every result against a behavioural copy of the allocator. It covers
// reuse of spare entries, merges back into the gap, full tables, several
// region sizes and random stalls on both sides.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int E     = tebs_pkg::ENTRIES_DEF;
    localparam int SB    = tebs_pkg::SIZE_BITS_DEF;
    localparam int LIMIT = 10000000;
    localparam logic [1:0] CMD_QUERY = 2'd2;
    localparam logic [1:0] CMD_SPARE = 2'd3;
    // two copies of allocator state: one predicts results, one steers stimulus
    localparam int PRED = 0;
    localparam int GEN  = 1;

    typedef logic [SB-1:0] t_sz;

    typedef struct {
        logic [1:0]  cmd;
        logic [15:0] pitch;
        logic [15:0] rows;
        t_sz         asz;
        t_sz         foff;
    } t_req;

    typedef struct {
        tebs_pkg::t_status status;
        t_sz     offset;
        logic    primary;
        logic    recycled;
        t_sz     free_b;
        t_sz     used_b;
        t_sz     aligned_b;
        t_sz     frag_b;
    } t_resp;

    logic i_clk = 0;
    logic i_rst_n = 0;
    logic i_valid = 0;
    logic o_ready;
    logic [1:0] i_cmd = '0;
    logic [15:0] i_row_pitch = '0;
    logic [15:0] i_row_count = '0;
    t_sz i_aligned_size = '0;
    t_sz i_free_offset = '0;
    logic o_valid;
    logic i_ready = 0;
    logic [1:0] o_status;
    t_sz o_buffer_offset;
    logic o_is_primary;
    logic o_recycled;
    t_sz o_free_bytes;
    t_sz o_used_bytes;
    t_sz o_aligned_bytes;
    t_sz o_fragmented_bytes;
    logic i_cfg_we = 0;
    t_sz i_cfg_data = '0;

    two_ended_buffer_suballocator i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready),
        .i_cmd(i_cmd), .i_row_pitch(i_row_pitch), .i_row_count(i_row_count),
        .i_aligned_size(i_aligned_size), .i_free_offset(i_free_offset),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_status(o_status), .o_buffer_offset(o_buffer_offset),
        .o_is_primary(o_is_primary), .o_recycled(o_recycled),
        .o_free_bytes(o_free_bytes), .o_used_bytes(o_used_bytes),
        .o_aligned_bytes(o_aligned_bytes), .o_fragmented_bytes(o_fragmented_bytes),
        .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // allocator state, two copies
    t_sz region_size [2];
    t_sz low_mark [2];
    t_sz high_mark [2];
    t_sz used_off [2][E];
    t_sz used_len [2][E];
    t_sz used_al [2][E];
    int  used_n [2];
    t_sz spare_off [2][E];
    t_sz spare_len [2][E];
    t_sz spare_al [2][E];
    int  spare_n [2];
    t_sz used_sum [2];
    t_sz al_sum [2];
    t_sz spare_sum [2];

    t_req  pending_items [$];
    t_resp expected_results [$];
    int mismatches = 0;
    int items_sent = 0;
    int results_seen = 0;
    int status_hits [4] = '{0, 0, 0, 0};
    int recycles = 0;
    int cycles = 0;

    function automatic void clear_region(int m, t_sz total);
        region_size[m] = total;
        low_mark[m] = '0;
        high_mark[m] = total;
        used_n[m] = 0;
        spare_n[m] = 0;
        used_sum[m] = '0;
        al_sum[m] = '0;
        spare_sum[m] = '0;
    endfunction

    function automatic t_sz gap(int m);
        return (high_mark[m] >= low_mark[m]) ? high_mark[m] - low_mark[m] : '0;
    endfunction

    function automatic void take_spare(int m, int i);
        spare_sum[m] = spare_sum[m] - spare_len[m][i];
        for (int k = i; k + 1 < spare_n[m]; k++) begin
            spare_off[m][k] = spare_off[m][k+1];
            spare_len[m][k] = spare_len[m][k+1];
            spare_al[m][k] = spare_al[m][k+1];
        end
        spare_n[m]--;
    endfunction

    function automatic void add_used(int m, t_sz off, t_sz len, t_sz al);
        used_off[m][used_n[m]] = off;
        used_len[m][used_n[m]] = len;
        used_al[m][used_n[m]] = al;
        used_n[m]++;
        used_sum[m] = used_sum[m] + len;
        al_sum[m] = al_sum[m] + al;
    endfunction

    function automatic t_resp allocate_step(int m, t_req it);
        t_resp r;
        logic [31:0] size;
        int idx;
        t_sz eo, el, ea, ms, me;
        r = '{tebs_pkg::ST_OK, '0, 1'b0, 1'b0, '0, '0, '0, '0};
        idx = -1;
        if (it.cmd == tebs_pkg::CMD_ALLOC) begin
            size = (it.asz != 0) ? 32'(it.asz) : 32'(it.pitch) * 32'(it.rows);
            for (int i = 0; i < spare_n[m]; i++) begin
                if (idx < 0 && 32'(spare_len[m][i]) == size) idx = i;
            end
            if (idx >= 0) begin
                if (used_n[m] >= E) begin
                    r.status = tebs_pkg::ST_FULL;
                end else begin
                    r.offset = spare_off[m][idx];
                    add_used(m, spare_off[m][idx], spare_len[m][idx], spare_al[m][idx]);
                    take_spare(m, idx);
                    r.recycled = 1'b1;
                end
            end else if (size > 32'(gap(m))) begin
                r.status = tebs_pkg::ST_NO_ROOM;
            end else if (used_n[m] >= E) begin
                r.status = tebs_pkg::ST_FULL;
            end else begin
                if (it.asz != 0) begin
                    high_mark[m] = high_mark[m] - t_sz'(size);
                    r.offset = high_mark[m];
                end else begin
                    r.offset = low_mark[m];
                    r.primary = (low_mark[m] == 0);
                    low_mark[m] = low_mark[m] + t_sz'(size);
                end
                add_used(m, r.offset, t_sz'(size), it.asz);
            end
        end else if (it.cmd == tebs_pkg::CMD_FREE) begin
            for (int i = 0; i < used_n[m]; i++) begin
                if (idx < 0 && used_off[m][i] == it.foff) idx = i;
            end
            if (idx < 0) begin
                r.status = tebs_pkg::ST_NOT_FOUND;
            end else begin
                eo = used_off[m][idx];
                el = used_len[m][idx];
                ea = used_al[m][idx];
                ms = low_mark[m];
                me = high_mark[m];
                if (ea != 0 && eo == high_mark[m]) begin
                    high_mark[m] = high_mark[m] + el;
                end else if ({1'b0, eo} + {1'b0, el} == {1'b0, low_mark[m]}) begin
                    low_mark[m] = low_mark[m] - el;
                end else if (spare_n[m] >= E) begin
                    r.status = tebs_pkg::ST_FULL;
                end else begin
                    spare_off[m][spare_n[m]] = eo;
                    spare_len[m][spare_n[m]] = el;
                    spare_al[m][spare_n[m]] = ea;
                    spare_n[m]++;
                    spare_sum[m] = spare_sum[m] + el;
                end
                if (r.status == tebs_pkg::ST_OK) begin
                    used_sum[m] = used_sum[m] - el;
                    al_sum[m] = al_sum[m] - ea;
                    for (int k = idx; k + 1 < used_n[m]; k++) begin
                        used_off[m][k] = used_off[m][k+1];
                        used_len[m][k] = used_len[m][k+1];
                        used_al[m][k] = used_al[m][k+1];
                    end
                    used_n[m]--;
                    // fold spares touching a marker back into the gap
                    while (ms != low_mark[m] || me != high_mark[m]) begin
                        ms = low_mark[m];
                        me = high_mark[m];
                        for (int j = 0; j < spare_n[m]; j++) begin
                            if (spare_al[m][j] != 0 && spare_off[m][j] == high_mark[m]) begin
                                high_mark[m] = high_mark[m] + spare_len[m][j];
                                take_spare(m, j);
                                break;
                            end
                            if (spare_al[m][j] == 0 && {1'b0, spare_off[m][j]}
                                    + {1'b0, spare_len[m][j]} == {1'b0, low_mark[m]}) begin
                                low_mark[m] = low_mark[m] - spare_len[m][j];
                                take_spare(m, j);
                                break;
                            end
                        end
                    end
                end
            end
        end
        r.free_b = gap(m);
        r.used_b = used_sum[m];
        r.aligned_b = al_sum[m];
        r.frag_b = spare_sum[m];
        return r;
    endfunction

    // ---------------- driver ----------------
    int burst_left = 0;
    int gap_left = 0;
    logic in_taken = 0;

    always @(negedge i_clk) begin
        if (i_rst_n && (!i_valid || in_taken)) begin
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                i_valid <= 1'b0;
            end else if (pending_items.size() > 0) begin
                i_valid <= 1'b1;
                i_cmd <= pending_items[0].cmd;
                i_row_pitch <= pending_items[0].pitch;
                i_row_count <= pending_items[0].rows;
                i_aligned_size <= pending_items[0].asz;
                i_free_offset <= pending_items[0].foff;
                void'(pending_items.pop_front());
                if (burst_left > 0) begin
                    burst_left <= burst_left - 1;
                end else begin
                    burst_left <= $urandom_range(0, 12);
                    gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 20);
                end
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // ---------------- receiver ----------------
    logic hold_req = 0;
    logic hold_started = 0;
    int hold_cnt = 0;
    int rx_mode = 0;
    int rx_mode_left = 0;

    always @(negedge i_clk) begin
        if (rx_mode_left == 0) begin
            rx_mode <= $urandom_range(0, 3);
            rx_mode_left <= $urandom_range(20, 200);
        end else begin
            rx_mode_left <= rx_mode_left - 1;
        end
        if (hold_req && !hold_started) begin
            hold_started <= 1'b1;
            hold_cnt <= 3000;
            i_ready <= 1'b0;
        end else if (hold_cnt > 0) begin
            hold_cnt <= hold_cnt - 1;
            i_ready <= 1'b0;
        end else begin
            case (rx_mode)
                0: i_ready <= 1'b1;
                1: i_ready <= ($urandom_range(0, 1) == 1);
                2: i_ready <= ($urandom_range(0, 7) != 0);
                default: i_ready <= ($urandom_range(0, 7) == 0);
            endcase
        end
    end

    // ---------------- predictor and monitor ----------------
    always @(posedge i_clk) begin
        t_resp exp_r;
        t_req acc;
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("end of test: mismatches");
            $finish;
        end
        in_taken <= i_rst_n && i_valid && o_ready;
        if (i_rst_n && i_valid && o_ready) begin
            acc = '{i_cmd, i_row_pitch, i_row_count, i_aligned_size, i_free_offset};
            expected_results.insert(expected_results.size(), allocate_step(PRED, acc));
            items_sent <= items_sent + 1;
        end
        if (i_rst_n && o_valid && i_ready) begin
            results_seen <= results_seen + 1;
            if (expected_results.size() == 0) begin
                mismatches <= mismatches + 1;
                if (mismatches < 10) $display("unexpected item out at cycle %0d", cycles);
            end else begin
                exp_r = expected_results.pop_front();
                status_hits[exp_r.status] <= status_hits[exp_r.status] + 1;
                if (exp_r.recycled) recycles <= recycles + 1;
                if (o_status !== exp_r.status || o_buffer_offset !== exp_r.offset
                        || o_is_primary !== exp_r.primary || o_recycled !== exp_r.recycled
                        || o_free_bytes !== exp_r.free_b || o_used_bytes !== exp_r.used_b
                        || o_aligned_bytes !== exp_r.aligned_b
                        || o_fragmented_bytes !== exp_r.frag_b) begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10) begin
                        $display("mismatch cycle %0d:", cycles);
                        $display("  exp st=%0d off=%0d p=%0b r=%0b fr=%0d us=%0d al=%0d fg=%0d",
                                 exp_r.status, exp_r.offset, exp_r.primary,
                                 exp_r.recycled, exp_r.free_b, exp_r.used_b,
                                 exp_r.aligned_b, exp_r.frag_b);
                        $display("  got st=%0d off=%0d p=%0b r=%0b fr=%0d us=%0d al=%0d fg=%0d",
                                 o_status, o_buffer_offset, o_is_primary, o_recycled,
                                 o_free_bytes, o_used_bytes, o_aligned_bytes,
                                 o_fragmented_bytes);
                    end
                end
            end
        end
    end

    // ---------------- stimulus ----------------
    task automatic send(t_req it);
        t_resp dummy;
        dummy = allocate_step(GEN, it);
        while (pending_items.size() > 4) @(negedge i_clk);
        pending_items.insert(pending_items.size(), it);
    endtask

    task automatic plain(int pitch, int rows);
        send('{tebs_pkg::CMD_ALLOC, 16'(pitch), 16'(rows), '0, '0});
    endtask

    task automatic aligned(t_sz sz);
        send('{tebs_pkg::CMD_ALLOC, '0, '0, sz, '0});
    endtask

    task automatic release_at(t_sz off);
        send('{tebs_pkg::CMD_FREE, '0, '0, '0, off});
    endtask

    task automatic drain();
        while (pending_items.size() > 0 || i_valid || expected_results.size() > 0)
            @(negedge i_clk);
        repeat (20) @(negedge i_clk);
    endtask

    task automatic set_region(t_sz total);
        drain();
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_data <= total;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        clear_region(PRED, total);
        clear_region(GEN, total);
    endtask

    task automatic random_item();
        t_req it;
        int pick;
        it = '{tebs_pkg::CMD_ALLOC, '0, '0, '0, '0};
        pick = $urandom_range(0, 99);
        if (pick < 22) begin
            it.pitch = 16'($urandom_range(0, 16));
            it.rows = 16'($urandom_range(1, 8));
        end else if (pick < 42) begin
            it.asz = t_sz'($urandom_range(1, 128));
        end else if (pick < 50 && spare_n[GEN] > 0) begin
            // ask for exactly the length of a spare entry
            it.asz = spare_len[GEN][$urandom_range(0, spare_n[GEN] - 1)];
            if ($urandom_range(0, 1) == 0 && it.asz <= 16) begin
                it.pitch = 16'(it.asz);
                it.rows = 16'd1;
                it.asz = '0;
            end
        end else if (pick < 85) begin
            it.cmd = tebs_pkg::CMD_FREE;
            if (used_n[GEN] > 0 && $urandom_range(0, 9) != 0)
                it.foff = used_off[GEN][$urandom_range(0, used_n[GEN] - 1)];
            else
                it.foff = t_sz'($urandom_range(0, 4096));
        end else if (pick < 92) begin
            it.cmd = ($urandom_range(0, 1) == 0) ? CMD_QUERY : CMD_SPARE;
            it.pitch = 16'($urandom);
            it.rows = 16'($urandom);
            it.asz = t_sz'($urandom);
            it.foff = t_sz'($urandom);
        end else begin
            // noise over full field ranges
            it.cmd = 2'($urandom_range(0, 3));
            it.pitch = 16'($urandom);
            it.rows = 16'($urandom);
            it.asz = ($urandom_range(0, 1) == 0) ? '0 : t_sz'($urandom);
            it.foff = t_sz'($urandom);
        end
        send(it);
    endtask

    initial begin
        t_sz totals [4];
        clear_region(PRED, t_sz'(tebs_pkg::TOTAL_RESET));
        clear_region(GEN, t_sz'(tebs_pkg::TOTAL_RESET));
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: reset region, extremes, every command, zero sizes
        plain(0, 0);
        plain(0, 5);
        release_at('0);
        plain(65535, 65535);
        aligned(t_sz'(tebs_pkg::TOTAL_RESET));
        release_at(t_sz'(tebs_pkg::TOTAL_RESET + 1));
        plain(64, 64);
        aligned(27'h7FFFFFF);
        send('{CMD_QUERY, 16'hFFFF, 16'hFFFF, 27'h7FFFFFF, 27'h7FFFFFF});
        send('{CMD_SPARE, 16'hAAAA, 16'h5555, 27'h2AAAAAA, 27'h5555555});
        aligned(t_sz'(100));
        aligned(t_sz'(50));
        release_at(t_sz'(tebs_pkg::TOTAL_RESET - 100));
        aligned(t_sz'(100));
        release_at(t_sz'(tebs_pkg::TOTAL_RESET - 150));
        release_at(t_sz'(tebs_pkg::TOTAL_RESET - 100));
        release_at('0);

        set_region('0);
        plain(0, 1);
        plain(1, 1);
        aligned(t_sz'(1));
        release_at('0);

        set_region(27'd67108864);
        plain(65535, 1024);
        aligned(27'd67108864 - 27'd67107840);
        plain(1, 1);
        release_at('0);

        // used table full, then spare list full
        set_region(27'd4096);
        for (int i = 0; i < E; i++) plain(1, 1);
        plain(1, 1);
        for (int i = 0; i < E - 1; i++) release_at(t_sz'(i));
        plain(2, 1);
        release_at(t_sz'(E - 1));
        plain(3, 1);
        plain(3, 1);
        release_at(t_sz'(E + 2));
        plain(1, 1);

        // random phases over several region sizes
        totals = '{27'd2048, 27'd600, 27'h7FFFFFF, 27'd4096};
        for (int ph = 0; ph < 4; ph++) begin
            set_region(totals[ph]);
            for (int n = 0; n < 80; n++) begin
                random_item();
                if (ph == 1 && n == 30) hold_req = 1'b1;
                if (ph == 2 && n == 50) drain();
            end
        end

        drain();
        repeat (100) @(negedge i_clk);
        $display("%0d items, %0d results: ok %0d, no room %0d, not found %0d, full %0d",
                 items_sent, results_seen, status_hits[0], status_hits[1],
                 status_hits[2], status_hits[3]);
        $display("%0d recycled allocations over 7 region sizes", recycles);
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("%0d mismatches, %0d results outstanding", mismatches,
                     expected_results.size());
            $display("end of test: mismatches");
        end
        $finish;
    end
endmodule
